/* sv/tgs_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tgs_pkg
// Shared types and constants for the trilinear grid sampler.
// ---------------------------------------------------------------------------
package tgs_pkg;
  localparam int AxisCells = 16;
  localparam int ValueBits = 16;
  localparam int FracBits  = 8;
  localparam int AxisBits  = $clog2(AxisCells);
  localparam int AddrBits  = 3 * AxisBits;
  localparam int Depth     = AxisCells * AxisCells * AxisCells;
  localparam int PosBits   = 14;
  localparam int SizeBits  = 5;
  localparam int CfgIdxBits = 2;

  localparam logic [CfgIdxBits-1:0] CfgSizeX = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgSizeY = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgSizeZ = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_READ, ST_LERPX, ST_LERPY, ST_LERPZ
  } state_t;

  typedef struct packed {
    logic clr_wr;     // write zero at clear counter
    logic clr_inc;
    logic cap;        // capture item on accept
    logic rd_issue;   // issue read of corner rd_cnt
    logic rd_next;
    logic lerp_x;
    logic lerp_y;
    logic lerp_z;
  } ctrl_t;

  typedef struct packed {
    logic clr_done;
    logic rd_last;
  } stat_t;
endpackage
`default_nettype wire

/* sv/tgs_ram.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tgs_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
module tgs_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* sv/tgs_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tgs_ctrl
// Sequencer: clearing pass, write, 8 corner reads, lerp stages.
// ---------------------------------------------------------------------------
module tgs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic           req_type,
  input  wire tgs_pkg::stat_t stat,
  output tgs_pkg::ctrl_t      ctrl,
  output logic                busy,
  output logic                done
);
  tgs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tgs_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state_r)
      tgs_pkg::ST_CLEAR: begin
        ctrl.clr_wr = 1'b1;
        ctrl.clr_inc = 1'b1;
        if (stat.clr_done) state_nxt = tgs_pkg::ST_IDLE;
      end
      tgs_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl.cap = 1'b1;
          if (req_type) state_nxt = tgs_pkg::ST_READ;
        end
      end
      tgs_pkg::ST_READ: begin
        ctrl.rd_issue = 1'b1;
        ctrl.rd_next = 1'b1;
        if (stat.rd_last) state_nxt = tgs_pkg::ST_LERPX;
      end
      tgs_pkg::ST_LERPX: begin
        ctrl.lerp_x = 1'b1;
        state_nxt = tgs_pkg::ST_LERPY;
      end
      tgs_pkg::ST_LERPY: begin
        ctrl.lerp_y = 1'b1;
        state_nxt = tgs_pkg::ST_LERPZ;
      end
      tgs_pkg::ST_LERPZ: begin
        ctrl.lerp_z = 1'b1;
        done = 1'b1;
        state_nxt = tgs_pkg::ST_IDLE;
      end
      default: state_nxt = tgs_pkg::ST_IDLE;
    endcase
  end

  ap_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tgs_pkg::ST_IDLE) |-> !busy) else $error("busy in idle");
  ap_done_ret: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (state_r == tgs_pkg::ST_IDLE)) else $error("done not followed by idle");
  ap_sample_go: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && start && req_type) |=> (state_r == tgs_pkg::ST_READ))
    else $error("sample not started");
endmodule
`default_nettype wire

/* sv/tgs_dp.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tgs_dp
// Datapath: size regs, base/fraction, clamped addressing, grid RAM, lerps.
// ---------------------------------------------------------------------------
module tgs_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire tgs_pkg::ctrl_t                       ctrl,
  output tgs_pkg::stat_t                            stat,
  input  wire logic                                 cfg_valid,
  input  wire logic [tgs_pkg::CfgIdxBits-1:0]       cfg_index,
  input  wire logic [tgs_pkg::SizeBits-1:0]         cfg_data,
  input  wire logic                                 req_type,
  input  wire logic [tgs_pkg::AxisBits-1:0]         cell_x,
  input  wire logic [tgs_pkg::AxisBits-1:0]         cell_y,
  input  wire logic [tgs_pkg::AxisBits-1:0]         cell_z,
  input  wire logic signed [tgs_pkg::ValueBits-1:0] write_value,
  input  wire logic signed [tgs_pkg::PosBits-1:0]   pos_x,
  input  wire logic signed [tgs_pkg::PosBits-1:0]   pos_y,
  input  wire logic signed [tgs_pkg::PosBits-1:0]   pos_z,
  output logic signed [tgs_pkg::ValueBits-1:0]      result
);
  localparam int AB = tgs_pkg::AxisBits;
  localparam int FB = tgs_pkg::FracBits;
  localparam int VB = tgs_pkg::ValueBits;
  localparam int PB = tgs_pkg::PosBits;
  localparam int BB = PB - FB + 1;      // base index bits, signed; the half shift adds one
  localparam int SB = tgs_pkg::SizeBits;

  logic [SB-1:0] size_r [3];
  logic [AB-1:0] hi_c [3];              // effective size minus one
  logic signed [PB-1:0] pos_in [3];
  logic signed [BB-1:0] base_r [3];
  logic [FB-1:0] frac_r [3];
  logic [tgs_pkg::AddrBits-1:0] clr_cnt_r;
  logic [2:0] rd_cnt_r;
  logic rd_vld_r;
  logic [2:0] rd_tag_r;
  logic signed [VB-1:0] v_r [8];
  logic signed [VB-1:0] x_r [4];
  logic signed [VB-1:0] y_r [2];
  logic [AB-1:0] idx_c [3];
  logic [tgs_pkg::AddrBits-1:0] addr;
  logic [VB-1:0] wdata, rdata;
  logic we;
  logic wr_ok;

  function automatic logic signed [VB-1:0] lerp(input logic signed [VB-1:0] a,
      input logic signed [VB-1:0] b, input logic [FB-1:0] f);
    logic signed [VB:0] d;
    logic signed [VB+FB+1:0] p;
    d = {b[VB-1], b} - {a[VB-1], a};
    p = d * $signed({1'b0, f});
    return VB'(a + VB'(p >>> FB));
  endfunction

  assign pos_in[0] = pos_x;
  assign pos_in[1] = pos_y;
  assign pos_in[2] = pos_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) size_r[k] <= SB'(tgs_pkg::AxisCells);
    end else if (cfg_valid) begin
      case (cfg_index)
        tgs_pkg::CfgSizeX: size_r[0] <= cfg_data;
        tgs_pkg::CfgSizeY: size_r[1] <= cfg_data;
        tgs_pkg::CfgSizeZ: size_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (size_r[k] == '0) hi_c[k] = '0;
      else if (size_r[k] > SB'(tgs_pkg::AxisCells)) hi_c[k] = AB'(tgs_pkg::AxisCells - 1);
      else hi_c[k] = AB'(size_r[k] - 1'b1);
    end
  end

  assign wr_ok = ({1'b0, cell_x} <= {1'b0, hi_c[0]}) && ({1'b0, cell_y} <= {1'b0, hi_c[1]})
              && ({1'b0, cell_z} <= {1'b0, hi_c[2]});

  // shifted position, floor via arithmetic shift
  always_ff @(posedge clk) begin
    if (ctrl.cap) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [PB:0] c;
        c = {pos_in[k][PB-1], pos_in[k]} - (PB+1)'(1 << (FB - 1));
        base_r[k] <= BB'(c >>> FB);
        frac_r[k] <= c[FB-1:0];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [BB:0] i;
      i = {base_r[k][BB-1], base_r[k]} + (BB+1)'(rd_cnt_r[k]);
      if (i < 0) idx_c[k] = '0;
      else if (i > $signed({{(BB+1-AB){1'b0}}, hi_c[k]})) idx_c[k] = hi_c[k];
      else idx_c[k] = AB'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      rd_cnt_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctrl.clr_inc) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (ctrl.rd_next) rd_cnt_r <= rd_cnt_r + 1'b1;
      rd_vld_r <= ctrl.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_tag_r <= rd_cnt_r;
    if (rd_vld_r) v_r[rd_tag_r] <= rdata;
  end

  always_comb begin
    we = 1'b0;
    wdata = '0;
    addr = {idx_c[2], idx_c[1], idx_c[0]};
    if (ctrl.clr_wr) begin
      we = 1'b1;
      addr = clr_cnt_r;
    end else if (ctrl.cap && !req_type) begin
      we = wr_ok;
      wdata = write_value;
      addr = {cell_z, cell_y, cell_x};
    end
  end

  tgs_ram #(.Width(VB), .Depth(tgs_pkg::Depth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // last read lands in v_r only at the end of LERPX: x lerp uses rdata bypass
  always_ff @(posedge clk) begin
    if (ctrl.lerp_x) begin
      x_r[0] <= lerp(v_r[0], v_r[1], frac_r[0]);
      x_r[1] <= lerp(v_r[2], v_r[3], frac_r[0]);
      x_r[2] <= lerp(v_r[4], v_r[5], frac_r[0]);
      x_r[3] <= lerp(v_r[6], rdata, frac_r[0]);
    end
    if (ctrl.lerp_y) begin
      y_r[0] <= lerp(x_r[0], x_r[1], frac_r[1]);
      y_r[1] <= lerp(x_r[2], x_r[3], frac_r[1]);
    end
  end

  assign result = lerp(y_r[0], y_r[1], frac_r[2]);
  assign stat.clr_done = clr_cnt_r == '1;
  assign stat.rd_last = rd_cnt_r == 3'd7;

  ap_rd_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.lerp_x |-> (rd_cnt_r == 3'd0)) else $error("corner count misaligned");
  ap_last_vld: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.lerp_x |-> (rd_vld_r && rd_tag_r == 3'd7)) else $error("last corner missing");
  ap_no_we_rd: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rd_issue |-> !we) else $error("write during sample read");
endmodule
`default_nettype wire

/* sv/trilinear_grid_sampler_top.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// trilinear_grid_sampler_top
// Trilinear sampler over a 16^3 Q8.8 grid with clamp-to-edge addressing.
// Write item: accepted when idle, no result. Sample item: out_valid follows accept
//   after 8 corner reads through the single RAM port and the x, y and z lerps.
// Throughput: one write per cycle while idle; a new sample only after busy drops.
// Reset: a clearing pass zeroes all 4096 grid cells; busy stays high.
// The receiver cannot stall; out_valid is a one-cycle strobe.
// ---------------------------------------------------------------------------
module trilinear_grid_sampler_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_req_type,
  input  wire logic [3:0]         in_cell_x,
  input  wire logic [3:0]         in_cell_y,
  input  wire logic [3:0]         in_cell_z,
  input  wire logic signed [15:0] in_write_value,
  input  wire logic signed [13:0] in_pos_x,
  input  wire logic signed [13:0] in_pos_y,
  input  wire logic signed [13:0] in_pos_z,
  output logic                    out_valid,
  output logic signed [15:0]      out_sample_value,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [4:0]         cfg_data
);
  tgs_pkg::ctrl_t ctrl;
  tgs_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  tgs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .req_type(in_req_type),
    .stat(stat), .ctrl(ctrl), .busy(busy), .done(out_valid)
  );

  tgs_dp u_dp (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_type(in_req_type), .cell_x(in_cell_x), .cell_y(in_cell_y), .cell_z(in_cell_z),
    .write_value(in_write_value), .pos_x(in_pos_x), .pos_y(in_pos_y), .pos_z(in_pos_z),
    .result(out_sample_value)
  );
endmodule
`default_nettype wire

/* bench/tgs_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tgs_checker
// Watches the item, result and register channels of the grid sampler,
// predicts each sample value and compares it with what the block returns.
// ---------------------------------------------------------------------------
module tgs_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic               in_req_type,
  input  wire logic [3:0]         in_cell_x,
  input  wire logic [3:0]         in_cell_y,
  input  wire logic [3:0]         in_cell_z,
  input  wire logic signed [15:0] in_write_value,
  input  wire logic signed [13:0] in_pos_x,
  input  wire logic signed [13:0] in_pos_y,
  input  wire logic signed [13:0] in_pos_z,
  input  wire logic               out_valid,
  input  wire logic signed [15:0] out_sample_value,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [4:0]         cfg_data,
  output int                      err_cnt,
  output int                      pending,
  output int                      samples_seen
);
  logic signed [15:0] grid_mdl [tgs_pkg::Depth];
  logic [4:0] dim_x, dim_y, dim_z;
  logic signed [15:0] sample_q[$];

  function automatic int eff_dim(logic [4:0] r);
    if (r == 0) return 1;
    if (r > tgs_pkg::AxisCells) return tgs_pkg::AxisCells;
    return int'(r);
  endfunction

  function automatic int clip(int i, logic [4:0] r);
    if (i < 0) return 0;
    if (i > eff_dim(r) - 1) return eff_dim(r) - 1;
    return i;
  endfunction

  // a + floor((b-a)*f / 256); >>> on int floors
  function automatic int blend(int a, int b, int f);
    return a + (((b - a) * f) >>> tgs_pkg::FracBits);
  endfunction

  function automatic logic signed [15:0] interp(logic signed [13:0] px,
      logic signed [13:0] py, logic signed [13:0] pz);
    int c[3], bs[3], fr[3], v[8], x0, x1, x2, x3, y0, y1;
    c[0] = int'(px) - 128;
    c[1] = int'(py) - 128;
    c[2] = int'(pz) - 128;
    for (int k = 0; k < 3; k++) begin
      bs[k] = c[k] >>> tgs_pkg::FracBits;
      fr[k] = c[k] & 255;
    end
    for (int k = 0; k < 8; k++)
      v[k] = grid_mdl[clip(bs[0] + (k & 1), dim_x)
                      + clip(bs[1] + ((k >> 1) & 1), dim_y) * tgs_pkg::AxisCells
                      + clip(bs[2] + ((k >> 2) & 1), dim_z)
                        * tgs_pkg::AxisCells * tgs_pkg::AxisCells];
    x0 = blend(v[0], v[1], fr[0]);
    x1 = blend(v[2], v[3], fr[0]);
    x2 = blend(v[4], v[5], fr[0]);
    x3 = blend(v[6], v[7], fr[0]);
    y0 = blend(x0, x1, fr[1]);
    y1 = blend(x2, x3, fr[1]);
    return 16'(blend(y0, y1, fr[2]));
  endfunction

  task automatic report(string what, logic signed [15:0] got, logic signed [15:0] want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  initial begin
    err_cnt = 0;
    samples_seen = 0;
    pending = 0;
    foreach (grid_mdl[i]) grid_mdl[i] = '0;
    dim_x = 5'd16; dim_y = 5'd16; dim_z = 5'd16;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        samples_seen++;
        if (sample_q.size() == 0) report("unexpected sample", out_sample_value, 'x);
        else begin
          automatic logic signed [15:0] want = sample_q.pop_front();
          if (out_sample_value !== want) report("sample_value", out_sample_value, want);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tgs_pkg::CfgSizeX: dim_x = cfg_data;
          tgs_pkg::CfgSizeY: dim_y = cfg_data;
          tgs_pkg::CfgSizeZ: dim_z = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_req_type) sample_q = {sample_q, interp(in_pos_x, in_pos_y, in_pos_z)};
        else if (in_cell_x < eff_dim(dim_x) && in_cell_y < eff_dim(dim_y)
                 && in_cell_z < eff_dim(dim_z))
          grid_mdl[in_cell_x + in_cell_y * tgs_pkg::AxisCells
                   + in_cell_z * tgs_pkg::AxisCells * tgs_pkg::AxisCells] = in_write_value;
      end
      pending = sample_q.size();
    end
  end
endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Grid sampler bench: directed and random writes and samples over several
// grid sizes, with random idle gaps; results checked by tgs_checker.
// ---------------------------------------------------------------------------
module tb;
  localparam int StallLimit = 20000;
  localparam logic [1:0] CfgUnused = 2'd3;

  logic clk, rst_n, start, busy;
  logic in_req_type;
  logic [3:0] in_cell_x, in_cell_y, in_cell_z;
  logic signed [15:0] in_write_value, out_sample_value;
  logic signed [13:0] in_pos_x, in_pos_y, in_pos_z;
  logic out_valid, cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;
  int err_cnt, pending, samples_seen, idle_cycles, n_items;
  bit quiet_run;

  trilinear_grid_sampler_top uut (.*);
  tgs_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // watchdog: cycles with nothing accepted or returned
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic gap();
    if (!quiet_run && $urandom_range(99) < 11) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic push(bit typ, logic [3:0] cx, cy, cz, logic [15:0] wv,
                      logic [13:0] px, py, pz);
    gap();
    start <= 1;
    in_req_type <= typ;
    in_cell_x <= cx; in_cell_y <= cy; in_cell_z <= cz;
    in_write_value <= wv;
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    n_items++;
  endtask

  task automatic put_cell(logic [3:0] x, y, z, logic [15:0] v);
    push(0, x, y, z, v, 14'($urandom), 14'($urandom), 14'($urandom));
  endtask

  task automatic probe(logic [13:0] x, y, z);
    push(1, 4'($urandom), 4'($urandom), 4'($urandom), 16'($urandom), x, y, z);
  endtask

  task automatic drain();
    start <= 0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic set_dims(logic [4:0] x, y, z);
    drain();
    write_reg(tgs_pkg::CfgSizeX, x);
    write_reg(tgs_pkg::CfgSizeY, y);
    write_reg(tgs_pkg::CfgSizeZ, z);
    write_reg(CfgUnused, 5'($urandom));  // unused index, ignored
  endtask

  // mostly near the grid, sometimes anywhere in the field
  function automatic logic [13:0] rand_pos();
    if ($urandom_range(9) == 0) return 14'($urandom);
    return 14'($urandom_range(0, 4608) - 256);
  endfunction

  initial begin
    logic [4:0] dims [6][3] = '{'{16, 16, 16}, '{1, 1, 1}, '{0, 31, 5},
                                '{4, 4, 4}, '{16, 2, 9}, '{3, 16, 0}};
    rst_n = 0; start = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    in_req_type = 0; in_cell_x = 0; in_cell_y = 0; in_cell_z = 0;
    in_write_value = 0; in_pos_x = 0; in_pos_y = 0; in_pos_z = 0;
    quiet_run = 0; n_items = 0; idle_cycles = 0;
    repeat (12) @(negedge clk);
    rst_n = 1;
    // directed: extremes, clamping, ignored writes
    probe(0, 0, 0);
    put_cell(0, 0, 0, 16'sh7fff);
    put_cell(1, 0, 0, 16'sh8000);
    put_cell(0, 1, 0, 16'h0100);
    put_cell(15, 15, 15, 16'hffff);
    put_cell(0, 0, 1, 16'h1234);
    probe(14'd128, 14'd128, 14'd128);
    probe(14'd255, 14'd200, 14'd130);
    probe(14'sh2000, 14'sh2000, 14'sh2000);
    probe(14'h1fff, 14'h1fff, 14'h1fff);
    probe(14'h3fff, 14'd0, 14'h1fff);
    probe(14'd127, 14'd129, 14'd383);
    set_dims(2, 3, 1);
    put_cell(5, 0, 0, 16'h5555);
    put_cell(1, 2, 0, 16'haaaa);
    put_cell(1, 1, 1, 16'h7777);
    probe(14'd300, 14'd600, 14'd0);
    probe(14'h1fff, 14'h1fff, 14'h1fff);
    // random phases over several sizes
    for (int ph = 0; ph < 6; ph++) begin
      set_dims(dims[ph][0], dims[ph][1], dims[ph][2]);
      quiet_run = (ph == 2);
      for (int i = 0; i < 130; i++) begin
        if ($urandom_range(1))
          put_cell(4'($urandom), 4'($urandom), 4'($urandom), 16'($urandom));
        else probe(rand_pos(), rand_pos(), rand_pos());
      end
    end
    quiet_run = 0;
    drain();
    $display("%0d items sent, %0d samples checked over 7 grid sizes incl. 0/1/31",
             n_items, samples_seen);
    if (err_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

/* filelist.f */
sv/tgs_pkg.sv
sv/tgs_ram.sv
sv/tgs_ctrl.sv
sv/tgs_dp.sv
sv/trilinear_grid_sampler_top.sv
bench/tgs_checker.sv
bench/tb.sv
